@@ rtl/core/sbit_pkg.sv @@
// shared constants and flag types for the segment/box intersection test core
`default_nettype none

package sbit_pkg;

    localparam int COORD_BITS_DEF    = 13;
    localparam int MAX_HALF_SIZE_DEF = 64;
    localparam int HALF_BITS         = 7;

    // per-axis flags out of the slab stage
    typedef struct packed {
        logic zero;     // direction component is zero
        logic in_slab;  // start coordinate within [lo, hi]
    } slab_flags_t;

    // flags out of the cross-product stage
    typedef struct packed {
        logic pass_x;   // x slab alone leaves a non-empty part of [0, 1]
        logic pass_y;   // same for y
        logic any_zero; // one axis has zero direction, no cross check needed
    } cross_flags_t;

    function automatic int sbit_max(input int a, input int b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/sbit_slab.sv @@
// one axis of the slab test: direction, slab bounds, entry/exit numerators
`default_nettype none

module sbit_slab
    import sbit_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int HW         = HALF_BITS
) (
    input  wire logic                                          aclk,
    input  wire logic                                          load1,
    input  wire logic                                          load2,
    input  wire logic signed [COORD_BITS-1:0]                  p_start,
    input  wire logic signed [COORD_BITS-1:0]                  p_end,
    input  wire logic signed [COORD_BITS-1:0]                  p_center,
    input  wire logic        [HW-1:0]                          half,
    output logic signed [sbit_max(COORD_BITS, HW)+2:0]         en_num,
    output logic signed [sbit_max(COORD_BITS, HW)+2:0]         ex_num,
    output logic signed [sbit_max(COORD_BITS, HW)+2:0]         den,
    output slab_flags_t                                        flags
);

    localparam int N = sbit_max(COORD_BITS, HW) + 3;

    logic signed [N-1:0] p0_reg, d_reg, lo_reg, hi_reg;
    logic signed [N-1:0] en_reg, en_next, ex_reg, ex_next, den_reg, den_next;
    slab_flags_t         flags_reg, flags_next;
    logic signed [N-1:0] p0_s, pe_s, c_s, h_s;

    assign p0_s = N'(p_start);
    assign pe_s = N'(p_end);
    assign c_s  = N'(p_center);
    assign h_s  = signed'(N'(half));

    // stage 1: direction and slab bounds
    always_ff @(posedge aclk) begin
        if (load1) begin
            p0_reg <= p0_s;
            d_reg  <= pe_s - p0_s;
            lo_reg <= c_s - h_s;
            hi_reg <= c_s + h_s;
        end
    end

    // stage 2: orient so the denominator is non-negative
    always_comb begin
        flags_next.zero    = (d_reg == '0);
        flags_next.in_slab = (lo_reg <= p0_reg) && (p0_reg <= hi_reg);
        if (!d_reg[N-1]) begin
            en_next  = lo_reg - p0_reg;
            ex_next  = hi_reg - p0_reg;
            den_next = d_reg;
        end else begin
            en_next  = p0_reg - hi_reg;
            ex_next  = p0_reg - lo_reg;
            den_next = -d_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (load2) begin
            en_reg    <= en_next;
            ex_reg    <= ex_next;
            den_reg   <= den_next;
            flags_reg <= flags_next;
        end
    end

    assign en_num = en_reg;
    assign ex_num = ex_reg;
    assign den    = den_reg;
    assign flags  = flags_reg;

endmodule

`default_nettype wire

@@ rtl/core/sbit_cross.sv @@
// cross-multiplication of entry/exit parameters between the two axes
`default_nettype none

module sbit_cross
    import sbit_pkg::*;
#(
    parameter int N = COORD_BITS_DEF + 3
) (
    input  wire logic                    aclk,
    input  wire logic                    load,
    input  wire logic signed [N-1:0]     en_x,
    input  wire logic signed [N-1:0]     ex_x,
    input  wire logic signed [N-1:0]     den_x,
    input  wire slab_flags_t             flags_x,
    input  wire logic signed [N-1:0]     en_y,
    input  wire logic signed [N-1:0]     ex_y,
    input  wire logic signed [N-1:0]     den_y,
    input  wire slab_flags_t             flags_y,
    output logic signed [2*N-1:0]        ent_x_prod,  // en_x * den_y
    output logic signed [2*N-1:0]        ext_y_prod,  // ex_y * den_x
    output logic signed [2*N-1:0]        ent_y_prod,  // en_y * den_x
    output logic signed [2*N-1:0]        ext_x_prod,  // ex_x * den_y
    output cross_flags_t                 flags
);

    logic signed [2*N-1:0] enx_reg, exy_reg, eny_reg, exx_reg;
    logic signed [2*N-1:0] enx_next, exy_next, eny_next, exx_next;
    cross_flags_t          flags_reg, flags_next;

    always_comb begin
        enx_next = en_x * den_y;
        exy_next = ex_y * den_x;
        eny_next = en_y * den_x;
        exx_next = ex_x * den_y;
        // single-axis clip against [0, 1]: exit >= 0 and entry <= 1
        flags_next.pass_x   = flags_x.zero ? flags_x.in_slab
                                           : (!ex_x[N-1] && (en_x <= den_x));
        flags_next.pass_y   = flags_y.zero ? flags_y.in_slab
                                           : (!ex_y[N-1] && (en_y <= den_y));
        flags_next.any_zero = flags_x.zero || flags_y.zero;
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            enx_reg   <= enx_next;
            exy_reg   <= exy_next;
            eny_reg   <= eny_next;
            exx_reg   <= exx_next;
            flags_reg <= flags_next;
        end
    end

    assign ent_x_prod = enx_reg;
    assign ext_y_prod = exy_reg;
    assign ent_y_prod = eny_reg;
    assign ext_x_prod = exx_reg;
    assign flags      = flags_reg;

endmodule

`default_nettype wire

@@ rtl/core/segment_box_intersection_test_core.sv @@
// top level of the segment versus square box intersection test core
//
// usage:
//   input channel s_*: one word carries a segment (start and end point) and a
//   square box (center and half size); accepted when s_valid and s_ready are high
//   result channel m_*: one word per input word, m_hit set when the segment
//   touches the closed box (edges and corners count); accepted on m_valid & m_ready
//   the slab test is exact: entry/exit parameters stay rationals and are
//   compared by cross-multiplication, a zero direction on an axis passes only
//   when the start coordinate lies in that slab; half sizes above
//   MAX_HALF_SIZE are clamped
//   throughput: one word per cycle while m_ready is high, set by the four-stage pipeline
//   (bounds, orientation, cross products, final compare)
//   stall: each stage holds while the one after it is full and not moving, so
//   bubbles collapse and s_ready stays high while any stage is empty
//   reset: aresetn (synchronous, active low) clears all stage valid bits;
//   words in flight are dropped
`default_nettype none

module segment_box_intersection_test_core
    import sbit_pkg::*;
#(
    parameter int COORD_BITS    = COORD_BITS_DEF,
    parameter int MAX_HALF_SIZE = MAX_HALF_SIZE_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_seg_start_x,
    input  wire logic signed [COORD_BITS-1:0] s_seg_start_y,
    input  wire logic signed [COORD_BITS-1:0] s_seg_end_x,
    input  wire logic signed [COORD_BITS-1:0] s_seg_end_y,
    input  wire logic signed [COORD_BITS-1:0] s_box_center_x,
    input  wire logic signed [COORD_BITS-1:0] s_box_center_y,
    input  wire logic        [HALF_BITS-1:0]  s_box_half_size,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_hit
);

    // width of the clamped half size and of all slab arithmetic
    localparam int HB = $clog2(MAX_HALF_SIZE + 1);
    localparam int HW = sbit_max(HB, HALF_BITS);
    localparam int N  = sbit_max(COORD_BITS, HW) + 3;

    // ---------------------------------------------------------------
    // stage valid bits and per-stage advance
    // ---------------------------------------------------------------
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic free1, free2, free3, free4;

    // a stage may load when it is empty or its word is moving on
    assign free4 = !v4_reg || m_ready;
    assign free3 = !v3_reg || free4;
    assign free2 = !v2_reg || free3;
    assign free1 = !v1_reg || free2;

    assign s_ready = free1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (free1) v1_reg <= s_valid;
            if (free2) v2_reg <= v1_reg;
            if (free3) v3_reg <= v2_reg;
            if (free4) v4_reg <= v3_reg;
        end
    end

    // ---------------------------------------------------------------
    // half size clamp (in front of stage 1)
    // ---------------------------------------------------------------
    logic [HW-1:0] half_ext, half_sat;

    assign half_ext = HW'(s_box_half_size);
    assign half_sat = (half_ext > HW'(MAX_HALF_SIZE)) ? HW'(MAX_HALF_SIZE) : half_ext;

    // ---------------------------------------------------------------
    // stages 1 and 2: one slab lane per axis
    // ---------------------------------------------------------------
    logic signed [N-1:0] en_x, ex_x, den_x, en_y, ex_y, den_y;
    slab_flags_t         flags_x, flags_y;

    sbit_slab #(
        .COORD_BITS (COORD_BITS),
        .HW         (HW)
    ) u_slab_x (
        .aclk     (aclk),
        .load1    (free1),
        .load2    (free2),
        .p_start  (s_seg_start_x),
        .p_end    (s_seg_end_x),
        .p_center (s_box_center_x),
        .half     (half_sat),
        .en_num   (en_x),
        .ex_num   (ex_x),
        .den      (den_x),
        .flags    (flags_x)
    );

    sbit_slab #(
        .COORD_BITS (COORD_BITS),
        .HW         (HW)
    ) u_slab_y (
        .aclk     (aclk),
        .load1    (free1),
        .load2    (free2),
        .p_start  (s_seg_start_y),
        .p_end    (s_seg_end_y),
        .p_center (s_box_center_y),
        .half     (half_sat),
        .en_num   (en_y),
        .ex_num   (ex_y),
        .den      (den_y),
        .flags    (flags_y)
    );

    // ---------------------------------------------------------------
    // stage 3: cross products between the axes
    // ---------------------------------------------------------------
    logic signed [2*N-1:0] ent_x_prod, ext_y_prod, ent_y_prod, ext_x_prod;
    cross_flags_t          cross_flags;

    sbit_cross #(
        .N (N)
    ) u_cross (
        .aclk       (aclk),
        .load       (free3),
        .en_x       (en_x),
        .ex_x       (ex_x),
        .den_x      (den_x),
        .flags_x    (flags_x),
        .en_y       (en_y),
        .ex_y       (ex_y),
        .den_y      (den_y),
        .flags_y    (flags_y),
        .ent_x_prod (ent_x_prod),
        .ext_y_prod (ext_y_prod),
        .ent_y_prod (ent_y_prod),
        .ext_x_prod (ext_x_prod),
        .flags      (cross_flags)
    );

    // ---------------------------------------------------------------
    // stage 4: final decision, also the output register
    // ---------------------------------------------------------------
    // the clipped interval is non-empty iff every lower bound is at most
    // every upper bound; entry x <= exit y and entry y <= exit x are the
    // only pairs that need the cross products
    logic hit_reg, hit_next;

    always_comb begin
        hit_next = cross_flags.pass_x && cross_flags.pass_y
                && (cross_flags.any_zero
                    || ((ent_x_prod <= ext_y_prod) && (ent_y_prod <= ext_x_prod)));
    end

    always_ff @(posedge aclk) begin
        if (free4) begin
            hit_reg <= hit_next;
        end
    end

    assign m_valid = v4_reg;
    assign m_hit   = hit_reg;

`ifndef SYNTH
    // an accepted word always lands in the first stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> v1_reg)
        else $error("accepted word missing from stage 1");

    // a blocked word in stage 3 is kept, not overwritten or lost
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !free3) |=> v3_reg)
        else $error("stalled stage 3 word lost");

    // a stalled result holds its value in the output register
    assert property (@(posedge aclk) disable iff (!aresetn)
        (v4_reg && !m_ready) |=> (v4_reg && $stable(hit_reg)))
        else $error("stalled result changed");

    // the input side only blocks when every stage is full
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && !m_ready))
        else $error("input blocked with a bubble in the pipeline");
`endif

endmodule

`default_nettype wire

@@ tb/sv/tb.sv @@
// testbench for the segment versus square box intersection test core
`timescale 1ns / 1ps

module tb;
    import sbit_pkg::*;

    localparam int CW            = COORD_BITS_DEF;
    localparam int DIR_ROWS      = 24;
    localparam int RANDOM_WORDS  = 1700;
    localparam int TAIL_WORDS    = 150;   // last words run with no idling on either side
    localparam int HOLD_AT       = DIR_ROWS + 300;
    localparam int HOLD_CYCLES   = 100;   // long receiver hold-off, fills the pipeline
    localparam int DRAIN_CYCLES  = 16;
    localparam int QUIET_LIMIT   = 2000;  // cycles with no word moving on either side

    // one input word as the block sees it
    typedef struct {
        logic signed [CW-1:0]    sx;
        logic signed [CW-1:0]    sy;
        logic signed [CW-1:0]    ex;
        logic signed [CW-1:0]    ey;
        logic signed [CW-1:0]    cx;
        logic signed [CW-1:0]    cy;
        logic [HALF_BITS-1:0]    h;
    } seg_box_t;

    // directed row: geometry, plus a typed-in result where known is set
    typedef struct {
        int sx, sy, ex, ey, cx, cy, h;
        bit known;
        bit hit;
    } dir_row_t;

    // clock and reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;
    always #1 aclk = ~aclk;

    // block inputs, all known from time zero
    logic                  s_valid         = 1'b0;
    logic signed [CW-1:0]  s_seg_start_x   = '0;
    logic signed [CW-1:0]  s_seg_start_y   = '0;
    logic signed [CW-1:0]  s_seg_end_x     = '0;
    logic signed [CW-1:0]  s_seg_end_y     = '0;
    logic signed [CW-1:0]  s_box_center_x  = '0;
    logic signed [CW-1:0]  s_box_center_y  = '0;
    logic [HALF_BITS-1:0]  s_box_half_size = '0;
    logic                  m_ready         = 1'b0;

    // block outputs
    logic s_ready;
    logic m_valid;
    logic m_hit;

    segment_box_intersection_test_core dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_seg_start_x   (s_seg_start_x),
        .s_seg_start_y   (s_seg_start_y),
        .s_seg_end_x     (s_seg_end_x),
        .s_seg_end_y     (s_seg_end_y),
        .s_box_center_x  (s_box_center_x),
        .s_box_center_y  (s_box_center_y),
        .s_box_half_size (s_box_half_size),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_hit           (m_hit)
    );

    // expected hit flags, oldest first
    bit expected_hits[$];

    int  fail_count    = 0;
    int  words_sent    = 0;
    int  hits_seen     = 0;
    int  misses_seen   = 0;
    int  input_stalls  = 0;   // cycles with a word offered but s_ready low
    int  quiet_cycles  = 0;
    int  cycle_count   = 0;
    bit  tail_phase    = 1'b0;
    bit  hold_req      = 1'b0;

    // directed words: extremes, degenerate boxes, zero directions, edge and corner grazes,
    // clamping of the half size
    dir_row_t directed_table [DIR_ROWS] = '{
        // sx     sy     ex     ey     cx     cy     h   known hit
        '{    0,     0,     0,     0,     0,     0,   0, 1, 1},  // point on a zero-size box
        '{    5,     5,     5,     5,     0,     0,   4, 1, 0},  // point outside
        '{    4,     4,     4,     4,     0,     0,   4, 1, 1},  // point on the corner
        '{  -10,     4,    10,     4,     0,     0,   4, 1, 1},  // runs along the top edge
        '{  -10,     5,    10,     5,     0,     0,   4, 1, 0},  // one pixel above it
        '{    5,   -10,     5,    10,     0,     0,   4, 1, 0},  // vertical, outside
        '{   -4,   -10,    -4,    10,     0,     0,   4, 1, 1},  // vertical, on the left edge
        '{  -20,     0,    -5,     0,     0,     0,   4, 1, 0},  // stops short
        '{  -20,     0,    -4,     0,     0,     0,   4, 1, 1},  // ends on the edge
        '{    0,     8,     8,     0,     0,     0,   4, 1, 1},  // grazes the corner
        '{    0,     9,     9,     0,     0,     0,   4, 1, 0},  // just misses the corner
        '{   64,     0,    64,     0,     0,     0, 127, 1, 1},  // half size clamped to max
        '{   65,     0,    65,     0,     0,     0, 127, 1, 0},
        '{   65,     0,    65,     0,     0,     0,  65, 1, 0},
        '{   64,     0,    64,     0,     0,     0,  64, 1, 1},
        '{-4096, -4096,  4095,  4095,     0,     0,   0, 1, 1},  // full diagonal through center
        '{ 4095,  4095,  4095,  4095,  4095,  4095,  64, 1, 1},  // box past the top corner
        '{-4096, -4096,  4095, -4096, -4096, -4096,   0, 1, 1},  // bottom row from the corner
        '{ 4095, -4096, -4096,  4095,     0,     0,   0, 0, 0},
        '{   10,     4,   -10,     4,     0,     0,   4, 0, 0},  // reversed direction
        '{-4096,  4095,  4095, -4096,  4095,  4095,  64, 0, 0},
        '{  100,   -30,   -50,    90,    20,    20,  40, 0, 0},
        '{-3000,  2000,  1500, -2500,  -100,  -300, 127, 0, 0},
        '{ 4095,  4095, -4096, -4096, -4096,  4095,  64, 0, 0}
    };

    // clip the running parameter interval [tn/td, un/ud] by one slab, exact rationals
    function automatic bit clip_axis(input longint p0, input longint d,
                                     input longint lo, input longint hi,
                                     inout longint tn, inout longint td,
                                     inout longint un, inout longint ud);
        longint en, xn, den;
        // zero direction: the slab holds only if the start lies in it
        if (d == 0)
            return (p0 >= lo) && (p0 <= hi);
        if (d > 0) begin
            en  = lo - p0;
            xn  = hi - p0;
            den = d;
        end else begin
            en  = p0 - hi;
            xn  = p0 - lo;
            den = -d;
        end
        // denominators stay positive, so plain cross products order the fractions
        if (en * td > tn * den) begin
            tn = en;
            td = den;
        end
        if (xn * ud < un * den) begin
            un = xn;
            ud = den;
        end
        return tn * ud <= un * td;
    endfunction

    // exact slab test on the word as driven
    function automatic bit predict_hit(input seg_box_t w);
        longint h, tn, td, un, ud, sx, sy, cx, cy;
        bit hit;
        h  = longint'(w.h);
        if (h > MAX_HALF_SIZE_DEF)
            h = MAX_HALF_SIZE_DEF;
        sx = longint'(w.sx);
        sy = longint'(w.sy);
        cx = longint'(w.cx);
        cy = longint'(w.cy);
        tn = 0;
        td = 1;
        un = 1;
        ud = 1;
        hit = clip_axis(sx, longint'(w.ex) - sx, cx - h, cx + h, tn, td, un, ud);
        if (hit)
            hit = clip_axis(sy, longint'(w.ey) - sy, cy - h, cy + h, tn, td, un, ud);
        return hit;
    endfunction

    // offset from the box center: spread half the time, else right on or just past an edge
    function automatic int near_offset(input int eff, input int reach);
        case ($urandom_range(0, 7))
            0: return -eff;
            1: return eff;
            2: return -eff - 1;
            3: return eff + 1;
            default: return int'($urandom_range(0, 2 * reach)) - reach;
        endcase
    endfunction

    // random word: some fully random, most built around the box so hits are common
    function automatic seg_box_t random_word();
        seg_box_t w;
        int cx, cy, h, eff, reach, shape;
        if ($urandom_range(0, 9) < 3) begin
            w.sx = CW'($urandom);
            w.sy = CW'($urandom);
            w.ex = CW'($urandom);
            w.ey = CW'($urandom);
            w.cx = CW'($urandom);
            w.cy = CW'($urandom);
            w.h  = HALF_BITS'($urandom);
            return w;
        end
        cx = int'($urandom_range(0, 8191)) - 4096;
        cy = int'($urandom_range(0, 8191)) - 4096;
        case ($urandom_range(0, 9))
            7, 8:    h = $urandom_range(65, 127);
            9:       h = $urandom_range(0, 1) ? 0 : MAX_HALF_SIZE_DEF;
            default: h = $urandom_range(0, MAX_HALF_SIZE_DEF);
        endcase
        eff   = (h > MAX_HALF_SIZE_DEF) ? MAX_HALF_SIZE_DEF : h;
        reach = eff + int'($urandom_range(0, 160));
        // coordinates wrap at the field width, the predictor sees the same bits
        w.cx = CW'(cx);
        w.cy = CW'(cy);
        w.h  = HALF_BITS'(h);
        w.sx = CW'(cx + near_offset(eff, reach));
        w.sy = CW'(cy + near_offset(eff, reach));
        w.ex = CW'(cx + near_offset(eff, reach));
        w.ey = CW'(cy + near_offset(eff, reach));
        shape = $urandom_range(0, 19);
        if (shape == 0) begin
            w.ex = w.sx;
            w.ey = w.sy;
        end else if (shape <= 2) begin
            w.ex = w.sx;
        end else if (shape <= 4) begin
            w.ey = w.sy;
        end
        return w;
    endfunction

    // handshake monitor and result checker, sampled at the rising edge
    always @(posedge aclk) begin
        bit want;
        cycle_count <= cycle_count + 1;
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (s_valid && !s_ready)
                input_stalls <= input_stalls + 1;
            if (m_valid && m_ready) begin
                if (expected_hits.size() == 0) begin
                    $error("result word with nothing expected: hit=%0b", m_hit);
                    fail_count++;
                end else begin
                    want = expected_hits.pop_front();
                    if (m_hit !== want) begin
                        $error("hit mismatch: expected %0b, actual %0b", want, m_hit);
                        fail_count++;
                    end
                    if (m_hit === 1'b1)
                        hits_seen++;
                    else
                        misses_seen++;
                end
            end
        end
    end

    // receiver: random stall bursts, one long hold-off, steady ready in the tail
    initial begin
        int stall_left;
        bit hold_done;
        bit rx_noisy;
        stall_left = 0;
        hold_done  = 1'b0;
        forever begin
            @(posedge aclk);
            // calm stretches: one quarter of the time, with no random stalls
            rx_noisy = ((cycle_count / 150) % 4) != 3;
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (hold_req && !hold_done) begin
                hold_done  = 1'b1;
                stall_left = HOLD_CYCLES - 1;
                m_ready <= 1'b0;
            end else if (!tail_phase && rx_noisy && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 7);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog: nothing moved for too long
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
        $display("FAIL segment_box_intersection_test_core");
        $finish;
    end

    // sender: directed table first, then random words, then drain and report
    initial begin
        seg_box_t w;
        bit       want;
        bit       tx_noisy;
        int       idx;
        int       total;
        total = DIR_ROWS + RANDOM_WORDS;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        for (idx = 0; idx < total; idx++) begin
            if (idx < DIR_ROWS) begin
                w.sx = CW'(directed_table[idx].sx);
                w.sy = CW'(directed_table[idx].sy);
                w.ex = CW'(directed_table[idx].ex);
                w.ey = CW'(directed_table[idx].ey);
                w.cx = CW'(directed_table[idx].cx);
                w.cy = CW'(directed_table[idx].cy);
                w.h  = HALF_BITS'(directed_table[idx].h);
                want = directed_table[idx].known ? directed_table[idx].hit : predict_hit(w);
            end else begin
                w    = random_word();
                want = predict_hit(w);
            end
            tail_phase = (idx >= total - TAIL_WORDS);
            if (idx == HOLD_AT)
                hold_req = 1'b1;
            // keep offering back to back in calm stretches and while the receiver holds off
            tx_noisy = ((idx / 100) % 4) != 3 && !(idx >= HOLD_AT && idx < HOLD_AT + 40);
            if (!tail_phase && tx_noisy && $urandom_range(0, 3) == 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end
            s_valid         <= 1'b1;
            s_seg_start_x   <= w.sx;
            s_seg_start_y   <= w.sy;
            s_seg_end_x     <= w.ex;
            s_seg_end_y     <= w.ey;
            s_box_center_x  <= w.cx;
            s_box_center_y  <= w.cy;
            s_box_half_size <= w.h;
            do @(posedge aclk); while (!s_ready);
            expected_hits.push_back(want);
            words_sent++;
        end
        s_valid <= 1'b0;

        // wait for every result, then drain for anything stray
        while (expected_hits.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d words (%0d directed, %0d random): %0d hits, %0d misses",
                 words_sent, DIR_ROWS, words_sent - DIR_ROWS, hits_seen, misses_seen);
        $display("input held back for %0d cycles, incl. a %0d-cycle receiver hold-off",
                 input_stalls, HOLD_CYCLES);
        if (fail_count == 0) begin
            $display("PASS segment_box_intersection_test_core");
        end else begin
            $display("FAIL segment_box_intersection_test_core");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/sbit_pkg.sv
rtl/core/sbit_slab.sv
rtl/core/sbit_cross.sv
rtl/core/segment_box_intersection_test_core.sv
tb/sv/tb.sv
